/* hw/rtl/ptrs_pkg.sv */
// shared types and constants for the periodic task release scheduler
package ptrs_pkg;

  localparam int MAX_TASKS = 4;
  localparam int TASKS_DEF = 4;

  localparam int CMD_W      = 3;
  localparam int TASK_W     = 2;
  localparam int TICKS_W    = 32;
  localparam int MASK_W     = 4;
  localparam int INTERVAL_W = 16;
  localparam int COUNT_W    = 8;

  // stream payload widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RUN     = 3'd4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET [MAX_TASKS] =
    '{16'd500, 16'd10000, 16'd5, 16'd1000};

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DONE
  } state_t;

endpackage

/* hw/rtl/periodic_task_release_scheduler_core.sv */
// periodic task release scheduler: tick sequencer, task state and result register
// order: a tick beat walks the tasks one per cycle through a shared subtract/compare
//   unit, then its result is registered once the output is free; other beats go straight there
// throughput: one beat in flight; the input is ready again the cycle after the result
//   register is loaded, even while that result still waits for m_tready
// reset (rst, synchronous, active high): tick counter, task state and flags cleared,
//   intervals back to 500/10000/5/1000, output empty; no clearing pass is needed
module periodic_task_release_scheduler_core #(
  parameter int TASKS = ptrs_pkg::TASKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input beat
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tdata: task_index[1:0], pause_ticks[33:2], zero fill
  input  logic [ptrs_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: cmd[2:0]
  input  logic [ptrs_pkg::CMD_W-1:0]       s_tuser,
  // result beat
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tdata: task_reported[1:0], resumed_mask[5:2], released_mask[9:6],
  //        run_mask[13:10], pending_mask[17:14], zero fill
  output logic [ptrs_pkg::OUT_DATA_W-1:0]  m_tdata,
  // tuser: kind[2:0]
  output logic [ptrs_pkg::CMD_W-1:0]       m_tuser,
  // interval register writes
  input  logic                             cfg_we,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ptrs_pkg::*;

  localparam int IDXW = (TASKS > 1) ? $clog2(TASKS) : 1;

  // control
  state_t state, state_next;
  logic [IDXW-1:0] idx;
  logic in_beat, out_load, last_task, tick_step;

  // architectural state
  logic [INTERVAL_W-1:0] interval [MAX_TASKS];
  logic [TICKS_W-1:0]    now_ticks;
  logic [TASKS-1:0]      task_enabled;
  logic [TICKS_W-1:0]    pause_left    [TASKS];
  logic [TICKS_W-1:0]    last_release  [TASKS];
  logic [COUNT_W-1:0]    pending_count [TASKS];

  // latched beat and tick masks
  logic [CMD_W-1:0]   op_cmd;
  logic [TASK_W-1:0]  op_task;
  logic [TICKS_W-1:0] op_ticks;
  logic [MASK_W-1:0]  res_mask, rel_mask;

  // shared unit for the task under the sequencer
  logic [TICKS_W-1:0] cur_pause, pause_after, elapsed;
  logic resume_hit, due;

  // non-tick command decode
  logic op_valid_task, op_reports;
  logic [IDXW-1:0] op_idx;
  logic [MASK_W-1:0] run_mask, pend_after;

  assign in_beat   = s_tvalid && s_tready;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign last_task = (idx == IDXW'(TASKS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = (s_tuser == CMD_TICK) ? ST_TICK : ST_DONE;
        end
      end
      ST_TICK: begin
        if (last_task) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    tick_step = 1'b0;
    case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_TICK: tick_step = 1'b1;
      ST_DONE: ;
      default: ;
    endcase
  end

  // one task per cycle: pause countdown, then the unsigned elapsed-time compare
  always_comb begin
    cur_pause   = pause_left[idx];
    resume_hit  = (cur_pause == TICKS_W'(1));
    pause_after = (cur_pause != '0) ? cur_pause - TICKS_W'(1) : '0;
    elapsed     = now_ticks - last_release[idx];
    due         = task_enabled[idx] && (pause_after == '0) &&
                  ({{(TICKS_W-INTERVAL_W){1'b0}}, interval[2'(idx)]} <= elapsed);
  end

  // single-task commands and run pass
  assign op_valid_task = ({1'b0, op_task} < (TASK_W+1)'(TASKS));
  assign op_idx        = IDXW'(op_task);
  assign op_reports    = (op_cmd == CMD_PAUSE) || (op_cmd == CMD_ENABLE) ||
                         (op_cmd == CMD_DISABLE);

  always_comb begin
    run_mask   = '0;
    pend_after = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (op_cmd == CMD_RUN) begin
        run_mask[i]   = (pending_count[i] != '0);
        pend_after[i] = (pending_count[i] > COUNT_W'(1));
      end else begin
        pend_after[i] = (pending_count[i] != '0);
      end
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      now_ticks    <= '0;
      task_enabled <= '0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        interval[i] <= INTERVAL_RESET[i];
      end
      for (int i = 0; i < TASKS; i++) begin
        pause_left[i]    <= '0;
        last_release[i]  <= '0;
        pending_count[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        interval[cfg_index] <= cfg_data;
      end

      // counter advances at accept so every task sees the new time
      if (in_beat) begin
        idx <= '0;
        if (s_tuser == CMD_TICK) begin
          now_ticks <= now_ticks + TICKS_W'(1);
        end
      end

      if (tick_step) begin
        idx             <= idx + IDXW'(1);
        pause_left[idx] <= pause_after;
        if (due) begin
          last_release[idx] <= now_ticks;
          if (pending_count[idx] != COUNT_MAX) begin
            pending_count[idx] <= pending_count[idx] + COUNT_W'(1);
          end
        end
      end

      if (out_load) begin
        case (op_cmd)
          CMD_PAUSE: begin
            if (op_valid_task) begin
              pause_left[op_idx] <= op_ticks;
            end
          end
          CMD_ENABLE: begin
            if (op_valid_task) begin
              task_enabled[op_idx] <= 1'b1;
            end
          end
          CMD_DISABLE: begin
            if (op_valid_task) begin
              task_enabled[op_idx] <= 1'b0;
            end
          end
          CMD_RUN: begin
            for (int i = 0; i < TASKS; i++) begin
              if (pending_count[i] != '0) begin
                pending_count[i] <= pending_count[i] - COUNT_W'(1);
              end
            end
          end
          default: ;
        endcase
      end

      // result register holds until taken; a new load may replace a taken beat
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_cmd   <= s_tuser;
      op_task  <= s_tdata[TASK_W-1:0];
      op_ticks <= s_tdata[TASK_W +: TICKS_W];
      res_mask <= '0;
      rel_mask <= '0;
    end
    if (tick_step) begin
      res_mask[2'(idx)] <= resume_hit;
      rel_mask[2'(idx)] <= due;
    end
    if (out_load) begin
      m_tuser <= op_cmd;
      m_tdata <= {
        (OUT_DATA_W - TASK_W - 4*MASK_W)'(0),
        pend_after,
        run_mask,
        (op_cmd == CMD_TICK) ? rel_mask : MASK_W'(0),
        (op_cmd == CMD_TICK) ? res_mask : MASK_W'(0),
        op_reports ? op_task : TASK_W'(0)
      };
    end
  end

  // a tick beat moves the counter by exactly one
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_tuser == CMD_TICK) |=> (now_ticks == $past(now_ticks) + TICKS_W'(1)))
    else $error("tick counter did not advance by one");

  // the sequencer never walks past the last task
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK) |-> ({1'b0, idx} < (IDXW+1)'(TASKS)))
    else $error("task sequencer index out of range");

  // releases only go to enabled tasks
  a_release_enabled: assert property (@(posedge clk) disable iff (rst)
    (tick_step && due) |-> task_enabled[idx])
    else $error("release given to a disabled task");

  // a loaded run mask only names tasks that had pending releases
  a_run_pending: assert property (@(posedge clk) disable iff (rst)
    out_load |=> ((m_tdata[TASK_W+2*MASK_W +: MASK_W] &
                   ~$past(pend_after | run_mask)) == '0))
    else $error("run mask names a task with nothing pending");

endmodule
